// ===== sv/asc_pkg.sv =====
// shared constants, result type and length capping for the start code splitter
`default_nettype none

package asc_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int FIELD_BITS  = 24;
   localparam int BYTE_BITS   = 8;
   localparam int WIN_DEPTH   = 3;
   localparam int SEQ_DEPTH   = WIN_DEPTH + 1;
   localparam int FILL_BITS   = $clog2(SEQ_DEPTH);
   localparam int AVAIL_BITS  = $clog2(SEQ_DEPTH + 1);
   localparam int CAP_BITS    = (LENGTH_BITS > FIELD_BITS) ? LENGTH_BITS : FIELD_BITS;

   localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = {LENGTH_BITS{1'b1}};
   localparam logic [FIELD_BITS-1:0]  FIELD_MAX = {FIELD_BITS{1'b1}};

   localparam logic [1:0] SKIP_LONG  = 2'd3;
   localparam logic [1:0] SKIP_SHORT = 2'd2;

   localparam logic [AVAIL_BITS-1:0] AVAIL_LONG  = AVAIL_BITS'(4);
   localparam logic [AVAIL_BITS-1:0] AVAIL_SHORT = AVAIL_BITS'(3);

   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WIN_DEPTH);

   typedef struct packed {
      logic [BYTE_BITS-1:0]  out_byte;
      logic                  unit_begin;
      logic                  long_code;
      logic [FIELD_BITS-1:0] closed_length;
   } asc_rsp_type;

   function automatic logic [FIELD_BITS-1:0] cap_len(input logic [LENGTH_BITS-1:0] v);
      logic [CAP_BITS-1:0] ext;
      ext = CAP_BITS'(v);
      if (ext > CAP_BITS'(FIELD_MAX)) begin
         return FIELD_MAX;
      end
      return FIELD_BITS'(ext);
   endfunction

endpackage

`default_nettype wire

// ===== sv/annexb_start_code_splitter.sv =====
// top level: annex b start code splitter with byte window and result register
//
// req channel takes one stream byte per beat with a last-byte flag; rsp channel
// gives one byte per beat, three stream positions late, flagged where a start
// code (00 00 00 01 tried first, then 00 00 01) opens a new unit, with the
// length of the unit just closed. the first three bytes of a stream fill the
// window and give no beat; from then on each accepted byte gives one rsp beat
// in the next cycle, one byte per clock sustained while rsp_ready stays high.
// the last byte flushes the window: it gives up to four rsp beats, one per
// cycle while rsp_ready stays high, and req_ready stays low for the extra
// flush beats. the final rsp beat carries stream_end and the last unit length,
// after which the block starts a fresh stream.
// a single result register parts the channels: a new byte is taken while a
// result waits, as long as rsp_ready is high; a stalled rsp holds its beat and
// holds off req. reset clears window, counters and rsp_valid.
`default_nettype none

module annexb_start_code_splitter
   import asc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [BYTE_BITS-1:0]  req_data_byte,
   input  wire logic                  req_last_byte,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [BYTE_BITS-1:0]  rsp_out_byte,
   output      logic                  rsp_unit_begin,
   output      logic                  rsp_long_code,
   output      logic [FIELD_BITS-1:0] rsp_closed_length,
   output      logic                  rsp_stream_end,
   output      logic [FIELD_BITS-1:0] rsp_final_length
);

   logic [WIN_DEPTH-1:0][BYTE_BITS-1:0] win_ff, win_in;
   logic [FILL_BITS-1:0]                fill_ff, fill_in;
   logic [1:0]                          skip_ff, skip_in;
   logic [LENGTH_BITS-1:0]              len_ff, len_in;
   logic                                flush_ff, flush_in;
   logic [1:0]                          left_ff, left_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   asc_rsp_type                         rsp_ff, rsp_in;
   logic                                end_ff, end_in;
   logic [FIELD_BITS-1:0]               final_ff, final_in;

   logic                                slot_free;
   logic                                req_fire;
   logic                                emit;
   logic                                last_emit;
   logic [SEQ_DEPTH-1:0][BYTE_BITS-1:0] seq;
   logic [SEQ_DEPTH-1:0][BYTE_BITS-1:0] req_seq;
   logic [AVAIL_BITS-1:0]               avail;
   asc_rsp_type                         dec_rsp;
   logic [1:0]                          dec_skip;
   logic [LENGTH_BITS-1:0]              dec_len;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = slot_free && !flush_ff;
   assign req_fire  = req_valid && req_ready;

   // place the new byte right after the valid window entries
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (FILL_BITS'(i) < fill_ff) begin
            req_seq[i] = win_ff[i];
         end else if (FILL_BITS'(i) == fill_ff) begin
            req_seq[i] = req_data_byte;
         end else begin
            req_seq[i] = '0;
         end
      end
      req_seq[WIN_DEPTH] = (fill_ff == FILL_FULL) ? req_data_byte : '0;
   end

   always_comb begin
      if (flush_ff) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            seq[i] = win_ff[i];
         end
         seq[WIN_DEPTH] = '0;
         avail          = AVAIL_BITS'(left_ff);
      end else begin
         seq   = req_seq;
         avail = AVAIL_BITS'(fill_ff) + AVAIL_BITS'(1);
      end
   end

   asc_decide u_decide (
      .seq       (seq),
      .avail     (avail),
      .skip      (skip_ff),
      .len       (len_ff),
      .rsp       (dec_rsp),
      .skip_next (dec_skip),
      .len_next  (dec_len)
   );

   always_comb begin
      emit      = 1'b0;
      last_emit = 1'b0;
      win_in    = win_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      len_in    = len_ff;
      flush_in  = flush_ff;
      left_in   = left_ff;

      if (flush_ff) begin
         if (slot_free) begin
            emit      = 1'b1;
            last_emit = (left_ff == 2'd1);
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[WIN_DEPTH-1] = '0;
            left_in  = left_ff - 2'd1;
            flush_in = !last_emit;
         end
      end else if (req_fire) begin
         if (!req_last_byte && fill_ff != FILL_FULL) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
               if (FILL_BITS'(i) == fill_ff) begin
                  win_in[i] = req_data_byte;
               end
            end
            fill_in = fill_ff + FILL_BITS'(1);
         end else begin
            emit = 1'b1;
            for (int i = 0; i < WIN_DEPTH; i++) begin
               win_in[i] = req_seq[i + 1];
            end
            if (req_last_byte) begin
               fill_in = '0;
               if (fill_ff == '0) begin
                  last_emit = 1'b1;
               end else begin
                  flush_in = 1'b1;
                  left_in  = 2'(fill_ff);
               end
            end
         end
      end

      if (emit) begin
         skip_in = dec_skip;
         len_in  = dec_len;
      end
      // stream done: back to the reset state
      if (last_emit) begin
         skip_in = '0;
         len_in  = '0;
         win_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      end_in       = end_ff;
      final_in     = final_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = dec_rsp;
         end_in       = last_emit;
         final_in     = last_emit ? cap_len(dec_len) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fill_ff      <= '0;
         skip_ff      <= '0;
         len_ff       <= '0;
         flush_ff     <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
         len_ff       <= len_in;
         flush_ff     <= flush_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      end_ff   <= end_in;
      final_ff <= final_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_ff.out_byte;
   assign rsp_unit_begin    = rsp_ff.unit_begin;
   assign rsp_long_code     = rsp_ff.long_code;
   assign rsp_closed_length = rsp_ff.closed_length;
   assign rsp_stream_end    = end_ff;
   assign rsp_final_length  = final_ff;

endmodule

`default_nettype wire

// ===== sv/asc_decide.sv =====
// start code test for the byte at the head of the window, with skip and length update
`default_nettype none

module asc_decide
   import asc_pkg::*;
(
   input  wire logic [SEQ_DEPTH-1:0][BYTE_BITS-1:0] seq,
   input  wire logic [AVAIL_BITS-1:0]               avail,
   input  wire logic [1:0]                          skip,
   input  wire logic [LENGTH_BITS-1:0]              len,
   output      asc_rsp_type                         rsp,
   output      logic [1:0]                          skip_next,
   output      logic [LENGTH_BITS-1:0]              len_next
);

   logic is_long;
   logic is_short;
   logic zz;

   always_comb begin
      zz       = (seq[0] == '0) && (seq[1] == '0);
      is_long  = 1'b0;
      is_short = 1'b0;
      skip_next = skip;
      if (skip != 2'd0) begin
         skip_next = skip - 2'd1;
      end else begin
         // only codes that fit in the bytes still available
         if (avail >= AVAIL_LONG && zz && seq[2] == '0 && seq[3] == BYTE_BITS'(1)) begin
            is_long = 1'b1;
         end else if (avail >= AVAIL_SHORT && zz && seq[2] == BYTE_BITS'(1)) begin
            is_short = 1'b1;
         end
      end

      rsp.out_byte      = seq[0];
      rsp.unit_begin    = 1'b0;
      rsp.long_code     = 1'b0;
      rsp.closed_length = '0;
      len_next          = len;

      if (is_long || is_short) begin
         rsp.unit_begin    = 1'b1;
         rsp.long_code     = is_long;
         rsp.closed_length = cap_len(len);
         len_next          = LENGTH_BITS'(1);
         skip_next         = is_long ? SKIP_LONG : SKIP_SHORT;
      end else if (len < LEN_LIMIT) begin
         len_next = len + LENGTH_BITS'(1);
      end
   end

endmodule

`default_nettype wire
